// ===== sv/xxh32_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh32_pkg
// Constants, controller/datapath command and status types for the XXH32 core.
// ----------------------------------------------------------------------------
package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  // datapath operations
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;  // latch input word, append or start stripe
  localparam logic [3:0] OP_LANE    = 4'd2;  // one lane round, multiply stage A
  localparam logic [3:0] OP_LANE_B  = 4'd3;  // lane round, multiply stage B
  localparam logic [3:0] OP_START   = 4'd4;  // merge lanes or seed+PRIME5, add length
  localparam logic [3:0] OP_WORD_A  = 4'd5;  // buffered word times PRIME3
  localparam logic [3:0] OP_WORD_B  = 4'd6;  // add, rotl 17, times PRIME4
  localparam logic [3:0] OP_BYTE_A  = 4'd7;  // tail byte times PRIME5
  localparam logic [3:0] OP_BYTE_B  = 4'd8;  // add, rotl 11, times PRIME1
  localparam logic [3:0] OP_AVAL_A  = 4'd9;  // h ^= h>>15, times PRIME2
  localparam logic [3:0] OP_AVAL_B  = 4'd10; // h ^= h>>13, times PRIME3
  localparam logic [3:0] OP_AVAL_C  = 4'd11; // h ^= h>>16, finish
  localparam logic [3:0] OP_CLEAR   = 4'd12; // end of message

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] idx;   // lane, buffer entry or byte index
  } xxh32_cmd_t;

  typedef struct packed {
    logic       full_word;   // latched word carries 4 bytes
    logic       stripe_done; // latched word completed a stripe
    logic       last;        // latched word ends the message
    logic [1:0] fill;        // buffered words
    logic [1:0] tail_n;      // tail bytes of a partial last word
  } xxh32_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== sv/xxh32_datapath.sv =====
// ----------------------------------------------------------------------------
// xxh32_datapath
// Lane accumulators, stripe buffer, length and one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module xxh32_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           seed,
  input  logic [31:0]           data_word,
  input  logic [2:0]            valid_bytes,
  input  logic                  last_word,
  input  xxh32_pkg::xxh32_cmd_t cmd,
  output xxh32_pkg::xxh32_sts_t sts,
  output logic [31:0]           hash
);

  logic [31:0] lane_acc [4];
  logic [31:0] stripe_buffer [3];
  logic [31:0] word;
  logic [1:0]  stripe_fill;
  logic [31:0] total_length;
  logic        stripe_seen;
  logic        full;
  logic        done;
  logic        last;
  logic [1:0]  tail_n;
  logic [31:0] h;
  logic [31:0] prod;    // registered multiplier output
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] lane_src;
  logic [31:0] lane_in;
  logic [31:0] hx;
  logic [7:0]  tail_byte;

  assign sts.full_word   = full;
  assign sts.stripe_done = done;
  assign sts.last        = last;
  assign sts.fill        = stripe_fill;
  assign sts.tail_n      = tail_n;
  assign hash            = h;

  // lane 3 uses the latched word, the others the buffer
  assign lane_src  = (cmd.idx == 2'd3) ? word : stripe_buffer[cmd.idx];
  assign lane_in   = stripe_seen ? lane_acc[cmd.idx] :
                     (cmd.idx == 2'd0) ? seed + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2 :
                     (cmd.idx == 2'd1) ? seed + xxh32_pkg::PRIME2 :
                     (cmd.idx == 2'd2) ? seed : seed - xxh32_pkg::PRIME1;
  assign tail_byte = word[8*cmd.idx +: 8];
  assign hx = (cmd.op == xxh32_pkg::OP_AVAL_A) ? h ^ (h >> 15) : h ^ (h >> 13);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      xxh32_pkg::OP_LANE:   begin mul_a = lane_src; mul_b = xxh32_pkg::PRIME2; end
      xxh32_pkg::OP_LANE_B: begin
        mul_a = xxh32_pkg::rotl(lane_in + prod, 13); mul_b = xxh32_pkg::PRIME1;
      end
      xxh32_pkg::OP_WORD_A: begin
        mul_a = stripe_buffer[cmd.idx]; mul_b = xxh32_pkg::PRIME3;
      end
      xxh32_pkg::OP_WORD_B: begin
        mul_a = xxh32_pkg::rotl(h + prod, 17); mul_b = xxh32_pkg::PRIME4;
      end
      xxh32_pkg::OP_BYTE_A: begin mul_a = {24'd0, tail_byte}; mul_b = xxh32_pkg::PRIME5; end
      xxh32_pkg::OP_BYTE_B: begin
        mul_a = xxh32_pkg::rotl(h + prod, 11); mul_b = xxh32_pkg::PRIME1;
      end
      xxh32_pkg::OP_AVAL_A: begin mul_a = hx; mul_b = xxh32_pkg::PRIME2; end
      xxh32_pkg::OP_AVAL_B: begin mul_a = hx; mul_b = xxh32_pkg::PRIME3; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (cmd.op)
      xxh32_pkg::OP_LOAD: begin
        word   <= data_word;
        last   <= last_word;
        full   <= !last_word || valid_bytes >= 3'd4;
        done   <= (!last_word || valid_bytes >= 3'd4) && stripe_fill == 2'd3;
        tail_n <= valid_bytes[1:0];
      end
      xxh32_pkg::OP_LANE_B: lane_acc[cmd.idx] <= mul_p;
      xxh32_pkg::OP_START: h <= (stripe_seen ?
          xxh32_pkg::rotl(lane_acc[0], 1) + xxh32_pkg::rotl(lane_acc[1], 7) +
          xxh32_pkg::rotl(lane_acc[2], 12) + xxh32_pkg::rotl(lane_acc[3], 18) :
          seed + xxh32_pkg::PRIME5) + total_length;
      xxh32_pkg::OP_WORD_B, xxh32_pkg::OP_BYTE_B,
      xxh32_pkg::OP_AVAL_A, xxh32_pkg::OP_AVAL_B: h <= mul_p;
      xxh32_pkg::OP_AVAL_C: h <= h ^ (h >> 16);
      default: ;
    endcase
    if (cmd.op == xxh32_pkg::OP_LOAD &&
        (!last_word || valid_bytes >= 3'd4) && stripe_fill != 2'd3)
      stripe_buffer[stripe_fill] <= data_word;
  end

  // control state of the message
  always_ff @(posedge clk) begin
    if (rst || cmd.op == xxh32_pkg::OP_CLEAR) begin
      stripe_fill  <= '0;
      total_length <= '0;
      stripe_seen  <= 1'b0;
    end else if (cmd.op == xxh32_pkg::OP_LOAD) begin
      if (!last_word || valid_bytes >= 3'd4) begin
        total_length <= total_length + 32'd4;
        stripe_fill  <= stripe_fill + 2'd1;  // wraps to 0 on a completed stripe
      end else begin
        total_length <= total_length + {30'd0, valid_bytes[1:0]};
      end
    end else if (cmd.op == xxh32_pkg::OP_LANE_B && cmd.idx == 2'd3) begin
      stripe_seen <= 1'b1;
    end
  end

endmodule

// ===== sv/xxh32_ctrl.sv =====
// ----------------------------------------------------------------------------
// xxh32_ctrl
// Sequencer: lane rounds, finalization steps and the handshakes.
// ----------------------------------------------------------------------------
module xxh32_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  xxh32_pkg::xxh32_sts_t sts,
  output xxh32_pkg::xxh32_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_LA    = 4'd2;
  localparam logic [3:0] S_LB    = 4'd3;
  localparam logic [3:0] S_START = 4'd4;
  localparam logic [3:0] S_WA    = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_BA    = 4'd7;
  localparam logic [3:0] S_BB    = 4'd8;
  localparam logic [3:0] S_AA    = 4'd9;
  localparam logic [3:0] S_AB    = 4'd10;
  localparam logic [3:0] S_AC    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic [1:0] nfill;       // buffered words at finalization

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = xxh32_pkg::OP_NONE;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = xxh32_pkg::OP_LOAD;
        state_next = S_DEC;
      end
      S_DEC: begin
        idx_next = '0;
        if (sts.stripe_done) state_next = S_LA;
        else if (sts.last) state_next = S_START;
        else state_next = S_IDLE;
      end
      S_LA: begin cmd.op = xxh32_pkg::OP_LANE; state_next = S_LB; end
      S_LB: begin
        cmd.op = xxh32_pkg::OP_LANE_B;
        idx_next = idx + 2'd1;
        if (idx != 2'd3) state_next = S_LA;
        else if (sts.last) state_next = S_START;
        else state_next = S_IDLE;
      end
      S_START: begin
        cmd.op = xxh32_pkg::OP_START;
        idx_next = '0;
        if (sts.fill != 2'd0) state_next = S_WA;
        else if (!sts.full_word && sts.tail_n != 2'd0) state_next = S_BA;
        else state_next = S_AA;
      end
      S_WA: begin cmd.op = xxh32_pkg::OP_WORD_A; state_next = S_WB; end
      S_WB: begin
        cmd.op = xxh32_pkg::OP_WORD_B;
        idx_next = idx + 2'd1;
        if (idx + 2'd1 != nfill) state_next = S_WA;
        else begin
          idx_next = '0;
          state_next = (!sts.full_word && sts.tail_n != 2'd0) ? S_BA : S_AA;
        end
      end
      S_BA: begin cmd.op = xxh32_pkg::OP_BYTE_A; state_next = S_BB; end
      S_BB: begin
        cmd.op = xxh32_pkg::OP_BYTE_B;
        idx_next = idx + 2'd1;
        state_next = (idx + 2'd1 != sts.tail_n) ? S_BA : S_AA;
      end
      S_AA: begin cmd.op = xxh32_pkg::OP_AVAL_A; state_next = S_AB; end
      S_AB: begin cmd.op = xxh32_pkg::OP_AVAL_B; state_next = S_AC; end
      S_AC: begin cmd.op = xxh32_pkg::OP_AVAL_C; state_next = S_OUT; end
      S_OUT: if (out_ready) begin
        cmd.op = xxh32_pkg::OP_CLEAR;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign nfill = sts.fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== sv/xxhash32_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// xxhash32_stream_hasher_core
// Streaming XXH32 over little-endian words with a programmable seed.
// A word is loaded and decoded; one closing a stripe adds four lane rounds.
// Last word: start, word A/B per buffered word, byte A/B per tail byte,
// avalanche A-C; the result then waits in an output register until taken.
// The single shared 32x32 multiplier sets the rate; one item at a time.
// Reset: synchronous; seed 0, message state empty, no result pending.
// ----------------------------------------------------------------------------
module xxhash32_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  logic [31:0]           seed;
  xxh32_pkg::xxh32_cmd_t cmd;
  xxh32_pkg::xxh32_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) seed <= '0;
    else if (cfg_valid) seed <= cfg_data;
  end

  xxh32_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  xxh32_datapath u_dp (
    .clk, .rst, .seed, .data_word, .valid_bytes, .last_word, .cmd, .sts,
    .hash(hash_value)
  );

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output both open");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("result dropped");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("no return to idle");

endmodule
